FILE: sv/rcl_pkg.sv
// Package: shared constants, types and register indexes of the reflectance line position block.
package rcl_pkg;

  localparam int SENSOR_COUNT = 6;
  localparam int TICK_WIDTH_DEF = 10;

  localparam int TIMEOUT_W = 10;
  localparam int LOST_W = 6;
  localparam int ERR_W = 7;
  localparam int TIME_W = 10;
  localparam int TRACK_W = 2;
  localparam int COUNT_W = 3;
  localparam int SUM_W = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_SAT = 2'd2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 10'd500;
  localparam logic [LOST_W-1:0] LOST_THR_RST = 6'd10;
  localparam logic [LOST_W-1:0] LOST_SAT_RST = 6'd45;

  localparam logic [TRACK_W-1:0] TRACK_UNKNOWN = 2'd0;
  localparam logic [TRACK_W-1:0] TRACK_DARK = 2'd1;
  localparam logic [TRACK_W-1:0] TRACK_LIGHT = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic signed [SUM_W-1:0] WEIGHTS [SENSOR_COUNT] =
    '{-8'sd35, -8'sd20, -8'sd8, 8'sd8, 8'sd20, 8'sd35};

  typedef logic [SENSOR_COUNT-1:0][TIME_W-1:0] times_t;

  typedef struct packed {
    logic [SENSOR_COUNT-1:0] undis;
    times_t times;
  } scan_rec_t;

endpackage

FILE: sv/rcl_if.sv
// Interfaces: input item channel and result channel.
interface rcl_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [rcl_pkg::SENSOR_COUNT-1:0] pin_levels;
  modport source (output valid, output op, output pin_levels, input ready);
  modport sink (input valid, input op, input pin_levels, output ready);
endinterface

interface rcl_out_if;
  logic valid;
  logic ready;
  logic signed [rcl_pkg::ERR_W-1:0] position_error;
  logic [rcl_pkg::TRACK_W-1:0] track_type;
  logic [rcl_pkg::SENSOR_COUNT-1:0] line_flags;
  logic [rcl_pkg::COUNT_W-1:0] active_count;
  logic [rcl_pkg::TIME_W-1:0] time_sensor0;
  logic [rcl_pkg::TIME_W-1:0] time_sensor1;
  logic [rcl_pkg::TIME_W-1:0] time_sensor2;
  logic [rcl_pkg::TIME_W-1:0] time_sensor3;
  logic [rcl_pkg::TIME_W-1:0] time_sensor4;
  logic [rcl_pkg::TIME_W-1:0] time_sensor5;
  modport source (output valid, output position_error, output track_type, output line_flags,
                  output active_count, output time_sensor0, output time_sensor1,
                  output time_sensor2, output time_sensor3, output time_sensor4,
                  output time_sensor5, input ready);
  modport sink (input valid, input position_error, input track_type, input line_flags,
                input active_count, input time_sensor0, input time_sensor1,
                input time_sensor2, input time_sensor3, input time_sensor4,
                input time_sensor5, output ready);
endinterface

FILE: sv/rcl_front.sv
// Front end: scan control, per-sensor discharge timing, finished scan records.
module rcl_front #(
  parameter int TICK_WIDTH = rcl_pkg::TICK_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_op,
  input  logic [rcl_pkg::SENSOR_COUNT-1:0] in_pins,
  input  logic [rcl_pkg::TIMEOUT_W-1:0] timeout,
  output logic push,
  output rcl_pkg::scan_rec_t push_rec,
  input  logic q_full
);
  import rcl_pkg::*;

  localparam int CMP_W = (TICK_WIDTH > TIMEOUT_W) ? TICK_WIDTH : TIMEOUT_W;
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

  logic active_r, active_nxt;
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic [SENSOR_COUNT-1:0] pend_r, pend_nxt;
  logic [TICK_WIDTH-1:0] times_r [SENSOR_COUNT];
  logic [TICK_WIDTH-1:0] times_nxt [SENSOR_COUNT];

  logic accept, run;
  logic [CMP_W-1:0] tmo_ext, tick_ext, tick_nxt_ext;
  logic [CMP_W-1:0] time_ext [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] fell;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign tmo_ext = CMP_W'(timeout);
  assign tick_ext = CMP_W'(tick_r);
  assign tick_nxt_ext = CMP_W'(tick_nxt);

  always_comb begin
    active_nxt = active_r;
    tick_nxt = tick_r;
    pend_nxt = pend_r;
    times_nxt = times_r;
    fell = '0;
    push = 1'b0;
    run = (tick_ext < tmo_ext);
    if (accept && in_op == OP_START) begin
      active_nxt = 1'b1;
      tick_nxt = '0;
      pend_nxt = '1;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        times_nxt[i] = tmo_ext[TICK_WIDTH-1:0];
      end
    end else if (accept && active_r) begin
      if (run) begin
        fell = pend_r & ~in_pins;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          if (fell[i]) begin
            times_nxt[i] = tick_r;
          end
        end
        pend_nxt = pend_r & ~fell;
        if (tick_r != TICK_MAX) begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      if (pend_nxt == '0 || tick_nxt_ext >= tmo_ext) begin
        push = 1'b1;
        active_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    push_rec.undis = pend_nxt;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      time_ext[i] = CMP_W'(times_nxt[i]);
      push_rec.times[i] = time_ext[i][TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      tick_r <= '0;
      pend_r <= '0;
    end else begin
      active_r <= active_nxt;
      tick_r <= tick_nxt;
      pend_r <= pend_nxt;
    end
    times_r <= times_nxt;
  end

endmodule

FILE: sv/rcl_fifo.sv
// Short queue of finished scan records between front and back end.
module rcl_fifo (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rcl_pkg::scan_rec_t push_rec,
  output logic full,
  input  logic pop,
  output rcl_pkg::scan_rec_t pop_rec,
  output logic not_empty
);
  import rcl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  scan_rec_t mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0] cnt_r;
  logic do_push, do_pop;

  assign full = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;
  assign pop_rec = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

endmodule

FILE: sv/rcl_back.sv
// Back end: polarity, line flags, weighted average by serial divider, result register.
module rcl_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  rcl_pkg::scan_rec_t q_rec,
  output logic q_pop,
  input  logic [rcl_pkg::LOST_W-1:0] lost_thr,
  input  logic [rcl_pkg::LOST_W-1:0] lost_sat,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [rcl_pkg::ERR_W-1:0] out_err,
  output logic [rcl_pkg::TRACK_W-1:0] out_track,
  output logic [rcl_pkg::SENSOR_COUNT-1:0] out_flags,
  output logic [rcl_pkg::COUNT_W-1:0] out_cnt,
  output rcl_pkg::times_t out_times
);
  import rcl_pkg::*;

  localparam int DIV_STEPS = ERR_W;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;

  state_t state_r, state_nxt;
  logic [TRACK_W-1:0] pol_r, pol_nxt;
  logic signed [ERR_W-1:0] last_err_r, last_err_nxt;
  logic [SENSOR_COUNT-1:0] flags_r, flags_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  times_t times_r, times_nxt;
  logic neg_r, neg_nxt;
  logic [ERR_W-1:0] quot_r, quot_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] step_r, step_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [ERR_W-1:0] out_err_r, out_err_nxt;
  logic [TRACK_W-1:0] out_track_r, out_track_nxt;
  logic [SENSOR_COUNT-1:0] out_flags_r, out_flags_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  times_t out_times_r, out_times_nxt;

  logic [TRACK_W-1:0] pol_new;
  logic [SENSOR_COUNT-1:0] undis, flags_new;
  logic signed [SUM_W-1:0] sum, mag;
  logic [COUNT_W-1:0] cnt_new;
  logic signed [SUM_W-1:0] last_ext, thr_ext;
  logic [ERR_W-1:0] sat_pos, lost_err;
  logic [COUNT_W:0] rem_sh;

  assign out_valid = out_valid_r;
  assign out_err = out_err_r;
  assign out_track = out_track_r;
  assign out_flags = out_flags_r;
  assign out_cnt = out_cnt_r;
  assign out_times = out_times_r;

  // polarity, flags, weighted sum of the record at the head of the queue
  always_comb begin
    undis = q_rec.undis;
    pol_new = pol_r;
    if (undis[0] && undis[5] && (!undis[2] || !undis[3])) pol_new = TRACK_DARK;
    if (!undis[0] && !undis[5] && (undis[2] || undis[3])) pol_new = TRACK_LIGHT;
    flags_new = (pol_new == TRACK_DARK) ? ~undis : undis;
    sum = '0;
    cnt_new = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (flags_new[i]) begin
        sum = sum + WEIGHTS[i];
        cnt_new = cnt_new + 1'b1;
      end
    end
    mag = sum[SUM_W-1] ? -sum : sum;
    last_ext = SUM_W'(last_err_r);
    thr_ext = SUM_W'({1'b0, lost_thr});
    sat_pos = ERR_W'({1'b0, lost_sat});
    if (last_ext > thr_ext) lost_err = sat_pos;
    else if (last_ext < -thr_ext) lost_err = ~sat_pos + 1'b1;
    else lost_err = '0;
  end

  always_comb begin
    state_nxt = state_r;
    pol_nxt = pol_r;
    last_err_nxt = last_err_r;
    flags_nxt = flags_r;
    cnt_nxt = cnt_r;
    times_nxt = times_r;
    neg_nxt = neg_r;
    quot_nxt = quot_r;
    rem_nxt = rem_r;
    step_nxt = step_r;
    err_nxt = err_r;
    out_valid_nxt = out_valid_r;
    out_err_nxt = out_err_r;
    out_track_nxt = out_track_r;
    out_flags_nxt = out_flags_r;
    out_cnt_nxt = out_cnt_r;
    out_times_nxt = out_times_r;
    q_pop = 1'b0;
    rem_sh = {rem_r, quot_r[ERR_W-1]};
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          pol_nxt = pol_new;
          flags_nxt = flags_new;
          cnt_nxt = cnt_new;
          times_nxt = q_rec.times;
          if (cnt_new == '0) begin
            err_nxt = lost_err;
            state_nxt = S_OUT;
          end else begin
            neg_nxt = sum[SUM_W-1];
            quot_nxt = mag[ERR_W-1:0];
            rem_nxt = '0;
            step_nxt = COUNT_W'(DIV_STEPS - 1);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, cnt_r}) begin
          rem_nxt = COUNT_W'(rem_sh - {1'b0, cnt_r});
          quot_nxt = {quot_r[ERR_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[COUNT_W-1:0];
          quot_nxt = {quot_r[ERR_W-2:0], 1'b0};
        end
        if (step_r == '0) begin
          err_nxt = neg_r ? (~quot_nxt + 1'b1) : quot_nxt;
          state_nxt = S_OUT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_err_nxt = err_r;
          out_track_nxt = pol_r;
          out_flags_nxt = flags_r;
          out_cnt_nxt = cnt_r;
          out_times_nxt = times_r;
          last_err_nxt = err_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pol_r <= TRACK_UNKNOWN;
      last_err_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pol_r <= pol_nxt;
      last_err_r <= last_err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    flags_r <= flags_nxt;
    cnt_r <= cnt_nxt;
    times_r <= times_nxt;
    neg_r <= neg_nxt;
    quot_r <= quot_nxt;
    rem_r <= rem_nxt;
    step_r <= step_nxt;
    err_r <= err_nxt;
    out_err_r <= out_err_nxt;
    out_track_r <= out_track_nxt;
    out_flags_r <= out_flags_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_times_r <= out_times_nxt;
  end

endmodule

FILE: sv/rc_reflectance_line_position.sv
// Top level: RC reflectance sensor timing and line position error.
// A start item opens a scan; each tick item carries the six pin levels, and ticks may arrive
// back to back. A scan that ends puts its record in a two-entry queue, and in_if.ready drops
// only while that queue is full. For each finished scan the back end classifies the record,
// runs seven steps of the serial divider for the weighted average (none when no sensor sees
// the line), then loads the result register before it takes the next record.
module rc_reflectance_line_position #(
  parameter int TICK_WIDTH = rcl_pkg::TICK_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rcl_in_if.sink in_if,
  rcl_out_if.source out_if,
  input  logic cfg_we,
  input  logic [rcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rcl_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_r;
  logic [LOST_W-1:0] lost_thr_r, lost_sat_r;

  logic push, q_full, q_pop, q_valid;
  scan_rec_t push_rec, pop_rec;
  times_t out_times;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      lost_thr_r <= LOST_THR_RST;
      lost_sat_r <= LOST_SAT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_LOST_THR: lost_thr_r <= cfg_wdata[LOST_W-1:0];
        CFG_LOST_SAT: lost_sat_r <= cfg_wdata[LOST_W-1:0];
        default: ;
      endcase
    end
  end

  rcl_front #(.TICK_WIDTH(TICK_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .in_op(in_if.op), .in_pins(in_if.pin_levels),
    .timeout(timeout_r),
    .push(push), .push_rec(push_rec), .q_full(q_full)
  );

  rcl_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_rec(push_rec), .full(q_full),
    .pop(q_pop), .pop_rec(pop_rec), .not_empty(q_valid)
  );

  rcl_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_rec(pop_rec), .q_pop(q_pop),
    .lost_thr(lost_thr_r), .lost_sat(lost_sat_r),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_err(out_if.position_error), .out_track(out_if.track_type),
    .out_flags(out_if.line_flags), .out_cnt(out_if.active_count),
    .out_times(out_times)
  );

  assign out_if.time_sensor0 = out_times[0];
  assign out_if.time_sensor1 = out_times[1];
  assign out_if.time_sensor2 = out_times[2];
  assign out_if.time_sensor3 = out_times[3];
  assign out_if.time_sensor4 = out_times[4];
  assign out_if.time_sensor5 = out_times[5];

endmodule

FILE: sv/rcl_checker.sv
// Checker: port-level assertions on the result channel, bound to the top level.
module rcl_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic signed [rcl_pkg::ERR_W-1:0] out_err,
  input logic [rcl_pkg::SENSOR_COUNT-1:0] out_flags,
  input logic [rcl_pkg::COUNT_W-1:0] out_cnt
);
  import rcl_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_err) && $stable(out_flags))
    else $error("stalled result changed");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cnt == COUNT_W'($countones(out_flags)))
    else $error("active count does not match line flags");

  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cnt != '0 |-> out_err <= 7'sd35 && out_err >= -7'sd35)
    else $error("weighted average outside weight range");

endmodule

bind rc_reflectance_line_position rcl_checker u_rcl_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_err(out_if.position_error),
  .out_flags(out_if.line_flags),
  .out_cnt(out_if.active_count)
);
